// ===== design/indexed_list_engine_macros.svh =====
// Assertion macros shared by the checker of the indexed list engine.
// Depends on nothing; the including scope supplies clk and rst_n.
`ifndef INDEXED_LIST_ENGINE_MACROS_SVH
`define INDEXED_LIST_ENGINE_MACROS_SVH

// Same-cycle implication, held off during reset.
`define ILE_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("indexed_list_engine: assertion failed");

// Next-cycle implication, held off during reset.
`define ILE_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("indexed_list_engine: assertion failed");

`endif

// ===== design/ile_pkg.sv =====
// Shared constants, codes and controller/datapath interface types for the
// indexed list engine. No dependencies.
`default_nettype none

package ile_pkg;

  localparam int CAPACITY   = 16;
  localparam int VALUE_BITS = 32;
  localparam int CMD_W      = 3;
  localparam int POS_W      = 5;
  localparam int STAT_W     = 2;
  localparam int IDX_W      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W      = $clog2(CAPACITY + 1);

  typedef logic signed [VALUE_BITS-1:0] value_t;

  typedef enum logic [CMD_W-1:0] {
    CMD_READ       = 3'd0,
    CMD_INS_HEAD   = 3'd1,
    CMD_INS_TAIL   = 3'd2,
    CMD_INS_BEFORE = 3'd3,
    CMD_DELETE     = 3'd4
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    ST_DONE   = 2'd0,
    ST_BADPOS = 2'd1,
    ST_FULL   = 2'd2
  } status_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_in;   // capture the accepted transaction
    logic setup;     // latch the decision and the shift bounds
    logic rd_en;     // read one entry and step the read index
    logic wr_shift;  // write the last read entry to its new slot
    logic commit;    // store the new value / update the count
    logic load_out;  // load the result register
  } ctrl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    status_t st;
    logic    is_read;
    logic    is_ins;
    logic    is_del;
    logic    no_move;
    logic    at_end;
  } stat_t;

endpackage

`default_nettype wire

// ===== design/ile_datapath.sv =====
// Datapath of the indexed list engine: entry memory, count, shift indices and
// result register. Depends on ile_pkg.
`default_nettype none

module ile_datapath (
  input  logic                            clk,
  input  logic                            rst_n,
  input  ile_pkg::ctrl_t                  ctrl,
  input  logic [ile_pkg::CMD_W-1:0]       in_cmd,
  input  logic [ile_pkg::POS_W-1:0]       in_position,
  input  ile_pkg::value_t                 in_value,
  output ile_pkg::stat_t                  stat,
  output ile_pkg::value_t                 out_read_value,
  output logic [ile_pkg::STAT_W-1:0]      out_status,
  output logic [ile_pkg::CNT_W-1:0]       out_length
);
  import ile_pkg::*;

  value_t               mem [CAPACITY];
  value_t               rdata_r;
  logic [CMD_W-1:0]     cmd_r;
  logic [POS_W-1:0]     pos_r;
  value_t               val_r;
  logic [CNT_W-1:0]     count_r;
  logic [IDX_W-1:0]     rd_idx_r;
  logic [IDX_W-1:0]     end_idx_r;
  logic [IDX_W-1:0]     wr_addr_r;
  logic [IDX_W-1:0]     tpos_r;
  logic                 ins_r;
  logic                 read_ok_r;
  status_t              status_r;

  logic [CNT_W-1:0]     pos_c;
  logic [CNT_W-1:0]     cnt_m1;
  logic [CNT_W-1:0]     pos_p1;
  logic [CNT_W-1:0]     tpos_c;
  logic                 full;
  status_t              st_c;
  logic                 ok;
  logic                 is_ins_cmd;
  logic [IDX_W-1:0]     start_c;
  logic [IDX_W-1:0]     end_c;

  always_comb begin
    pos_c  = CNT_W'(pos_r);
    cnt_m1 = count_r - 1'b1;
    pos_p1 = pos_c + 1'b1;
    full   = (count_r == CNT_W'(CAPACITY));
    tpos_c = pos_c;
    st_c   = ST_DONE;
    is_ins_cmd = 1'b0;
    case (cmd_r)
      CMD_READ: begin
        if (pos_c >= count_r) st_c = ST_BADPOS;
      end
      CMD_INS_HEAD: begin
        is_ins_cmd = 1'b1;
        tpos_c     = '0;
        if (full) st_c = ST_FULL;
      end
      CMD_INS_TAIL: begin
        is_ins_cmd = 1'b1;
        tpos_c     = count_r;
        if (full) st_c = ST_FULL;
      end
      CMD_INS_BEFORE: begin
        is_ins_cmd = 1'b1;
        if (pos_c > count_r) st_c = ST_BADPOS;
        else if (full)       st_c = ST_FULL;
      end
      CMD_DELETE: begin
        if (pos_c >= count_r) st_c = ST_BADPOS;
      end
      default: st_c = ST_BADPOS;
    endcase
    ok = (st_c == ST_DONE);

    stat.st      = st_c;
    stat.is_read = ok && (cmd_r == CMD_READ);
    stat.is_ins  = ok && is_ins_cmd;
    stat.is_del  = ok && (cmd_r == CMD_DELETE);
    stat.no_move = is_ins_cmd ? (tpos_c == count_r) : (pos_p1 == count_r);
    stat.at_end  = (rd_idx_r == end_idx_r);

    // Inserts walk down from the last entry, deletes walk up past the hole.
    if (is_ins_cmd) begin
      start_c = cnt_m1[IDX_W-1:0];
      end_c   = tpos_c[IDX_W-1:0];
    end else if (cmd_r == CMD_DELETE) begin
      start_c = pos_p1[IDX_W-1:0];
      end_c   = cnt_m1[IDX_W-1:0];
    end else begin
      start_c = pos_c[IDX_W-1:0];
      end_c   = pos_c[IDX_W-1:0];
    end
  end

  // Entry memory: one read port with registered data, one write port.
  always_ff @(posedge clk) begin
    if (ctrl.rd_en) begin
      rdata_r <= mem[rd_idx_r];
    end
    if (ctrl.wr_shift) begin
      mem[wr_addr_r] <= rdata_r;
    end else if (ctrl.commit && ins_r) begin
      mem[tpos_r] <= val_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (ctrl.commit) begin
      count_r <= ins_r ? count_r + 1'b1 : count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load_in) begin
      cmd_r <= in_cmd;
      pos_r <= in_position;
      val_r <= in_value;
    end
    if (ctrl.setup) begin
      status_r  <= st_c;
      read_ok_r <= ok && (cmd_r == CMD_READ);
      ins_r     <= is_ins_cmd;
      tpos_r    <= tpos_c[IDX_W-1:0];
      rd_idx_r  <= start_c;
      end_idx_r <= end_c;
    end else if (ctrl.rd_en) begin
      wr_addr_r <= ins_r ? rd_idx_r + 1'b1 : rd_idx_r - 1'b1;
      rd_idx_r  <= ins_r ? rd_idx_r - 1'b1 : rd_idx_r + 1'b1;
    end
    if (ctrl.load_out) begin
      out_read_value <= read_ok_r ? rdata_r : '1;
      out_status     <= status_r;
      out_length     <= count_r;
    end
  end

endmodule

`default_nettype wire

// ===== design/ile_ctrl.sv =====
// Controller of the indexed list engine: sequences decision, entry reads and shifting,
// commit and result hand-off. Depends on ile_pkg.
`default_nettype none

module ile_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  input  ile_pkg::stat_t  stat,
  output ile_pkg::ctrl_t  ctrl
);
  import ile_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECIDE,
    S_SHIFT,
    S_DRAIN,
    S_RDWAIT,
    S_COMMIT,
    S_FINISH
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   wr_pend_r, wr_pend_nxt;

  always_comb begin
    ctrl          = '0;
    state_nxt     = state_r;
    wr_pend_nxt   = wr_pend_r;
    out_valid_nxt = out_valid_r && !out_ready;
    in_ready      = (state_r == S_IDLE);
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          ctrl.load_in = 1'b1;
          state_nxt    = S_DECIDE;
        end
      end
      S_DECIDE: begin
        ctrl.setup  = 1'b1;
        wr_pend_nxt = 1'b0;
        if (stat.is_read)                     state_nxt = S_RDWAIT;
        else if (stat.is_ins || stat.is_del)  state_nxt = stat.no_move ? S_COMMIT : S_SHIFT;
        else                                  state_nxt = S_FINISH;
      end
      S_SHIFT: begin
        ctrl.rd_en    = 1'b1;
        ctrl.wr_shift = wr_pend_r;
        wr_pend_nxt   = 1'b1;
        if (stat.at_end) state_nxt = S_DRAIN;
      end
      S_DRAIN: begin
        ctrl.wr_shift = 1'b1;
        state_nxt     = S_COMMIT;
      end
      S_RDWAIT: begin
        ctrl.rd_en = 1'b1;
        state_nxt  = S_FINISH;
      end
      S_COMMIT: begin
        ctrl.commit = 1'b1;
        state_nxt   = S_FINISH;
      end
      S_FINISH: begin
        if (!out_valid_r || out_ready) begin
          ctrl.load_out = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      wr_pend_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      wr_pend_r   <= wr_pend_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

// ===== design/indexed_list_engine.sv =====
// Top level of the indexed list engine: joins controller and datapath.
// Depends on ile_pkg, ile_ctrl and ile_datapath.
//
// Usage
//   Input channel (in_valid/in_ready) carries one command transaction:
//   in_cmd (read, insert at head, insert at tail, insert before position,
//   delete at position), in_position and in_value. Every transaction yields
//   exactly one result transaction on out_valid/out_ready: out_read_value
//   (-1 unless a valid read), out_status and out_length after the command.
//   A refused command goes from decision straight to the final step; a read
//   first reads its entry; an insert or delete first shifts the entries it
//   moves, if any, and then commits. The entry memory's single read and
//   single write port set the shift pace: one entry moves per cycle, with
//   reads overlapping the write of the previous entry. One command is
//   worked on at a time; in_ready is high only while the engine is idle.
//   The result sits in an output register, so the next command is accepted
//   while a result still waits; a stalled receiver holds the engine in its
//   final step until the waiting result is taken.
//   Reset (synchronous, active low) empties the list; entry storage itself
//   is not cleared, as only entries below the length are ever read.
`default_nettype none

module indexed_list_engine (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [ile_pkg::CMD_W-1:0]         in_cmd,
  input  logic [ile_pkg::POS_W-1:0]         in_position,
  input  logic signed [ile_pkg::VALUE_BITS-1:0] in_value,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [ile_pkg::VALUE_BITS-1:0] out_read_value,
  output logic [ile_pkg::STAT_W-1:0]        out_status,
  output logic [ile_pkg::CNT_W-1:0]         out_length
);
  import ile_pkg::*;

  ctrl_t ctrl;
  stat_t stat;

  // Sequencer: decide, shift, commit, hand off.
  ile_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .ctrl      (ctrl)
  );

  // Storage, checks and result register.
  ile_datapath u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .ctrl           (ctrl),
    .in_cmd         (in_cmd),
    .in_position    (in_position),
    .in_value       (in_value),
    .stat           (stat),
    .out_read_value (out_read_value),
    .out_status     (out_status),
    .out_length     (out_length)
  );

endmodule

`default_nettype wire

// ===== design/ile_checker.sv =====
// Port-level checker for the indexed list engine, bound to the top level.
// Depends on ile_pkg and indexed_list_engine_macros.svh.
`default_nettype none

`include "indexed_list_engine_macros.svh"

module ile_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic [ile_pkg::CMD_W-1:0]         in_cmd,
  input logic [ile_pkg::POS_W-1:0]         in_position,
  input logic signed [ile_pkg::VALUE_BITS-1:0] in_value,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic signed [ile_pkg::VALUE_BITS-1:0] out_read_value,
  input logic [ile_pkg::STAT_W-1:0]        out_status,
  input logic [ile_pkg::CNT_W-1:0]         out_length
);
  import ile_pkg::*;

  // A stalled result holds.
  `ILE_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_read_value) && $stable(out_status) && $stable(out_length))
  // One command at a time: ready drops after an accepted transaction.
  `ILE_ASSERT_NXT(a_one_at_a_time, in_valid && in_ready, !in_ready)
  // The list never grows past its capacity.
  `ILE_ASSERT_NOW(a_len_bound, out_valid, out_length <= CNT_W'(CAPACITY))
  // A refused command reads back all ones.
  `ILE_ASSERT_NOW(a_refused_value, out_valid && (out_status != ST_DONE), out_read_value == '1)
  // A full refusal only happens on a full list.
  `ILE_ASSERT_NOW(a_full_len, out_valid && (out_status == ST_FULL), out_length == CNT_W'(CAPACITY))

endmodule

bind indexed_list_engine ile_checker u_ile_checker (.*);

`default_nettype wire
